### hdl/enpp_pkg.sv
package enpp_pkg;

	localparam logic [1:0] KIND_OPEN   = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_CLOSE  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_ESC_END   = 3'd1;
	localparam logic [2:0] ERR_UNMATCHED = 3'd2;
	localparam logic [2:0] ERR_TOO_DEEP  = 3'd3;
	localparam logic [2:0] ERR_UNCLOSED  = 3'd4;

	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_END    = 2'd1;
	localparam logic [1:0] REG_ESCAPE = 2'd2;

	localparam logic [7:0] START_RESET  = 8'd254;
	localparam logic [7:0] END_RESET    = 8'd255;
	localparam logic [7:0] ESCAPE_RESET = 8'd253;

	localparam int PADDR_W = 4;

	typedef struct packed {
		logic wr;
		logic rd;
	} stack_cmd_t;

endpackage

### hdl/enpp_if.sv
interface enpp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;
	logic       stream_last;

	modport source (output valid, output raw_byte, output stream_last, input ready);
	modport sink (input valid, input raw_byte, input stream_last, output ready);
endinterface

interface enpp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [7:0] event_value;
	logic [4:0] nest_depth;
	logic [2:0] error_code;

	modport source (output valid, output event_kind, output event_value,
		output nest_depth, output error_code, input ready);
	modport sink (input valid, input event_kind, input event_value,
		input nest_depth, input error_code, output ready);
endinterface

### hdl/enpp_type_stack.sv
module enpp_type_stack #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                clk,
	input  enpp_pkg::stack_cmd_t cmd,
	input  logic [AW-1:0]       addr,
	input  logic [7:0]          wdata,
	output logic [7:0]          rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
	end

	// The read register holds its value until the next read.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/escaped_nested_node_parser_unit.sv
// Channel   Dir  Payload                                          Transfer
// in_ch     in   raw_byte[7:0], stream_last                       valid & ready
// out_ch    out  event_kind, event_value, nest_depth, error_code   valid & ready
// APB       in   start/end/escape marker registers at 0x0/0x4/0x8  psel & penable & pwrite
//
// One byte is taken every cycle while input ready is high; a result is registered in the
// stage register and then in the output register. The type stack is a single-port memory;
// a close reads it at transfer time and the data is merged in the stage that follows.
// Reset loads the marker registers with their defaults and clears the parse
// state and both pipeline valids.
// A stalled output holds both stages; input ready drops only when both are full.
module escaped_nested_node_parser_unit #(
	parameter int MAX_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	enpp_in_if.sink                       in_ch,
	enpp_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [enpp_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_DEPTH);

	// Configuration registers.
	logic [7:0] start_q, end_q, esc_q;
	logic       cfg_wr;
	logic [1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= enpp_pkg::START_RESET;
			end_q   <= enpp_pkg::END_RESET;
			esc_q   <= enpp_pkg::ESCAPE_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				enpp_pkg::REG_START:  start_q <= pwdata[7:0];
				enpp_pkg::REG_END:    end_q   <= pwdata[7:0];
				enpp_pkg::REG_ESCAPE: esc_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			enpp_pkg::REG_START:  prdata = {24'd0, start_q};
			enpp_pkg::REG_END:    prdata = {24'd0, end_q};
			enpp_pkg::REG_ESCAPE: prdata = {24'd0, esc_q};
			default:              prdata = 32'd0;
		endcase
	end

	// Parse state.
	logic          esc_pend_q, await_q;
	logic [CW-1:0] cnt_q;

	// Pipeline stage and output register.
	logic          s1_valid_s1, s1_pop_s1;
	logic [1:0]    kind_s1;
	logic [7:0]    value_s1;
	logic [4:0]    depth_s1;
	logic [2:0]    err_s1;
	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [7:0]    out_value_q;
	logic [4:0]    out_depth_q;
	logic [2:0]    out_err_q;

	logic s1_adv, acc;

	assign s1_adv      = s1_valid_s1 & (~out_valid_q | out_ch.ready);
	assign in_ch.ready = ~s1_valid_s1 | ~out_valid_q | out_ch.ready;
	assign acc         = in_ch.valid & in_ch.ready;

	// Per-byte decode.
	logic [7:0]    b;
	logic          last;
	logic          have, push, pop, nxt_esc, nxt_await;
	logic [1:0]    kind;
	logic [7:0]    value;
	logic [2:0]    err;
	logic [CW-1:0] nxt_cnt, cnt_dec;
	logic [CW+4:0] depth_ext;

	assign b       = in_ch.raw_byte;
	assign last    = in_ch.stream_last;
	assign cnt_dec = cnt_q - CW'(1);

	always_comb begin
		have      = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		kind      = enpp_pkg::KIND_STATUS;
		value     = 8'd0;
		err       = enpp_pkg::ERR_NONE;
		nxt_cnt   = cnt_q;
		nxt_esc   = esc_pend_q;
		nxt_await = await_q;
		if (await_q) begin
			nxt_await = 1'b0;
			have      = 1'b1;
			if (cnt_q < MaxCnt) begin
				push    = 1'b1;
				nxt_cnt = cnt_q + CW'(1);
				kind    = enpp_pkg::KIND_OPEN;
				value   = b;
			end else begin
				err = enpp_pkg::ERR_TOO_DEEP;
			end
		end else if (esc_pend_q) begin
			nxt_esc = 1'b0;
			have    = 1'b1;
			kind    = enpp_pkg::KIND_DATA;
			value   = b;
		end else if (b == esc_q) begin
			if (last) begin
				err  = enpp_pkg::ERR_ESC_END;
				have = 1'b1;
			end else begin
				nxt_esc = 1'b1;
			end
		end else if (b == start_q) begin
			if (last) begin
				err  = enpp_pkg::ERR_UNCLOSED;
				have = 1'b1;
			end else begin
				nxt_await = 1'b1;
			end
		end else if (b == end_q) begin
			have = 1'b1;
			if (cnt_q == '0) begin
				err = enpp_pkg::ERR_UNMATCHED;
			end else begin
				pop     = 1'b1;
				nxt_cnt = cnt_dec;
				kind    = enpp_pkg::KIND_CLOSE;
			end
		end else begin
			have  = 1'b1;
			kind  = enpp_pkg::KIND_DATA;
			value = b;
		end
		if (last) begin
			have = 1'b1;
			if (err == enpp_pkg::ERR_NONE && nxt_cnt != '0) begin
				err = enpp_pkg::ERR_UNCLOSED;
			end
		end
	end

	assign depth_ext = {5'd0, nxt_cnt};

	// Type stack. A push and a pop never share a cycle, and a pop in the cycle
	// after a push reads the entry that the push has already written.
	enpp_pkg::stack_cmd_t stk_cmd;
	logic [AW-1:0]        stk_addr;
	logic [7:0]           stk_rdata;

	assign stk_cmd.wr = acc & push;
	assign stk_cmd.rd = acc & pop;
	assign stk_addr   = pop ? cnt_dec[AW-1:0] : cnt_q[AW-1:0];

	enpp_type_stack #(
		.DEPTH(MAX_DEPTH),
		.AW   (AW)
	) u_stack (
		.clk  (clk),
		.cmd  (stk_cmd),
		.addr (stk_addr),
		.wdata(b),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pend_q <= 1'b0;
			await_q    <= 1'b0;
			cnt_q      <= '0;
		end else if (acc) begin
			esc_pend_q <= nxt_esc & ~last;
			await_q    <= nxt_await & ~last;
			cnt_q      <= last ? '0 : nxt_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (acc & have) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc & have) begin
			kind_s1   <= kind;
			value_s1  <= value;
			depth_s1  <= depth_ext[4:0];
			err_s1    <= err;
			s1_pop_s1 <= pop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_kind_q  <= kind_s1;
			out_value_q <= s1_pop_s1 ? stk_rdata : value_s1;
			out_depth_q <= depth_s1;
			out_err_q   <= err_s1;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.event_kind  = out_kind_q;
	assign out_ch.event_value = out_value_q;
	assign out_ch.nest_depth  = out_depth_q;
	assign out_ch.error_code  = out_err_q;

endmodule

### hdl/enpp_checker.sv
module enpp_checker #(
	parameter int MAX_DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] event_kind,
	input logic [7:0] event_value,
	input logic [4:0] nest_depth,
	input logic [2:0] error_code
);

	// A result that is not taken stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind)
			&& $stable(event_value) && $stable(nest_depth) && $stable(error_code))
		else $error("output transfer changed while stalled");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (MAX_DEPTH > 31) || (nest_depth <= MAX_DEPTH))
		else $error("nest depth beyond stack depth");

	// Escape at end, unmatched close and too deep produce only a status result.
	a_hard_err_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == enpp_pkg::ERR_ESC_END
			|| error_code == enpp_pkg::ERR_UNMATCHED
			|| error_code == enpp_pkg::ERR_TOO_DEEP)
		|-> event_kind == enpp_pkg::KIND_STATUS && event_value == 8'd0)
		else $error("error result carries an event");

	a_unmatched_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == enpp_pkg::ERR_UNMATCHED |-> nest_depth == 5'd0)
		else $error("unmatched close with open nodes");

	a_event_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != enpp_pkg::KIND_STATUS
		|-> error_code == enpp_pkg::ERR_NONE || error_code == enpp_pkg::ERR_UNCLOSED)
		else $error("event result with an unexpected error code");

endmodule

bind escaped_nested_node_parser_unit enpp_checker #(
	.MAX_DEPTH(MAX_DEPTH)
) u_enpp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.event_kind (out_ch.event_kind),
	.event_value(out_ch.event_value),
	.nest_depth (out_ch.nest_depth),
	.error_code (out_ch.error_code)
);
